>>> hdl/sba_pkg.sv
// Shared types and constants for the slab bitmap allocator.
package sba_pkg;

  localparam int ADDR_W    = 39;
  localparam int LOG2_W    = 4;
  localparam int CNT_W     = 7;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 2;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_INIT  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE  = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FREE    = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_ADDR   = 2'd2;
  localparam logic [STAT_W-1:0] ST_DOUBLE_FREE = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJ_LOG2     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 2'd2;

  // Object size limits and register reset values
  localparam logic [LOG2_W-1:0] LOG2_MIN   = 4'd6;
  localparam logic [LOG2_W-1:0] LOG2_MAX   = 4'd11;
  localparam logic [LOG2_W-1:0] LOG2_RESET = 4'd6;
  localparam logic [CNT_W-1:0]  CAP_RESET  = 7'd64;
  localparam logic [CNT_W-1:0]  CNT_MAX    = 7'd127;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] object_address;
    logic [CNT_W-1:0]  free_count;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base_address;
    logic [LOG2_W-1:0] object_size_log2;
    logic [CNT_W-1:0]  slot_capacity;
  } cfg_t;

endpackage

>>> hdl/sba_if.sv
// Valid/ready channel interface carrying one item.
interface sba_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/sba_datapath.sv
// Single-pass allocate/free/init logic: result and next slab state for one item.
module sba_datapath #(
  parameter int MAX_SLOTS = 64
) (
  input  sba_pkg::req_t                req_item,
  input  sba_pkg::cfg_t                cfg,
  input  logic [MAX_SLOTS-1:0]         bitmap,
  input  logic [sba_pkg::CNT_W-1:0]    counter,
  output sba_pkg::rsp_t                rsp_item,
  output logic [MAX_SLOTS-1:0]         bitmap_next,
  output logic [sba_pkg::CNT_W-1:0]    counter_next
);
  import sba_pkg::*;

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [CNT_W-1:0] CAP_LIMIT = CNT_W'(MAX_SLOTS);

  logic [CNT_W-1:0]     cap_eff;
  logic [LOG2_W-1:0]    lg_eff;
  logic [MAX_SLOTS-1:0] cap_mask;
  logic [MAX_SLOTS-1:0] avail;
  logic [MAX_SLOTS-1:0] lowest;
  logic [IDX_W-1:0]     alloc_idx;
  logic                 alloc_ok;
  logic [ADDR_W-1:0]    alloc_addr;
  logic [ADDR_W-1:0]    offset;
  logic [ADDR_W-1:0]    free_idx;
  logic [IDX_W-1:0]     free_sel;
  logic                 out_of_range;
  logic                 was_free;

  // Clamp capacity and object size to their legal ranges
  assign cap_eff = (cfg.slot_capacity > CAP_LIMIT) ? CAP_LIMIT : cfg.slot_capacity;

  always_comb begin
    if (cfg.object_size_log2 < LOG2_MIN) begin
      lg_eff = LOG2_MIN;
    end else if (cfg.object_size_log2 > LOG2_MAX) begin
      lg_eff = LOG2_MAX;
    end else begin
      lg_eff = cfg.object_size_log2;
    end
  end

  // Slots below capacity
  always_comb begin
    for (int j = 0; j < MAX_SLOTS; j++) begin
      cap_mask[j] = (CNT_W'(j) < cap_eff);
    end
  end

  // Lowest free slot: isolate lowest set bit, then encode the one-hot
  assign avail  = bitmap & cap_mask;
  assign lowest = avail & (~avail + MAX_SLOTS'(1));

  always_comb begin
    alloc_idx = '0;
    for (int j = 0; j < MAX_SLOTS; j++) begin
      if (lowest[j]) begin
        alloc_idx = alloc_idx | IDX_W'(j);
      end
    end
  end

  assign alloc_ok   = (counter != '0) && (avail != '0);
  assign alloc_addr = cfg.base_address + (ADDR_W'(alloc_idx) << lg_eff);

  // Free: object index from the address offset
  assign offset       = req_item.free_address - cfg.base_address;
  assign free_idx     = offset >> lg_eff;
  assign out_of_range = (req_item.free_address < cfg.base_address) ||
                        (free_idx >= ADDR_W'(cap_eff));
  assign free_sel     = free_idx[IDX_W-1:0];
  assign was_free     = bitmap[free_sel];

  // Result and state update per action
  always_comb begin
    rsp_item.status         = ST_OK;
    rsp_item.object_address = '0;
    bitmap_next             = bitmap;
    counter_next            = counter;
    unique case (req_item.action)
      ACT_ALLOC: begin
        if (!alloc_ok) begin
          rsp_item.status = ST_NO_FREE;
        end else begin
          bitmap_next[alloc_idx]  = 1'b0;
          counter_next            = counter - CNT_W'(1);
          rsp_item.object_address = alloc_addr;
        end
      end
      ACT_FREE: begin
        if (out_of_range) begin
          rsp_item.status = ST_BAD_ADDR;
        end else if (was_free) begin
          rsp_item.status = ST_DOUBLE_FREE;
        end else begin
          bitmap_next[free_sel] = 1'b1;
          if (counter != CNT_MAX) begin
            counter_next = counter + CNT_W'(1);
          end
        end
      end
      ACT_INIT: begin
        bitmap_next  = cap_mask;
        counter_next = cap_eff;
      end
      ACT_NONE: begin
        rsp_item.status = ST_OK;
      end
    endcase
    rsp_item.free_count = counter_next;
  end

endmodule

>>> hdl/slab_bitmap_allocator.sv
// Slab bitmap allocator top level: config registers, item stages, slab state.
//
// Allocates and frees fixed-size objects of one slab of up to MAX_SLOTS objects.
// An item is taken into an input register, the allocate/free/init logic runs in
// one pass, and the result is loaded into an output register: every accepted
// item gives exactly one result, and while the output is not stalled a new item
// can be accepted every cycle, so the sustained rate is one item per clock. The
// free bitmap and free count update as the item moves into the output register,
// so each item sees the effect of the one before.
// Input ready follows output ready through the two stages; with the output
// stalled, two items are held (one in each register) before input ready drops.
// Configuration writes take effect at once and are meant to be made while no
// item is in flight.
module slab_bitmap_allocator #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sba_pkg::ADDR_W-1:0]      cfg_data,
  sba_if.sink                             req,
  sba_if.source                           rsp
);
  import sba_pkg::*;

  cfg_t                 cfg;
  logic [MAX_SLOTS-1:0] bitmap;
  logic [CNT_W-1:0]     counter;
  logic                 s1_valid;
  req_t                 s1_item;
  logic                 out_valid;
  rsp_t                 out_item;

  rsp_t                 dp_rsp;
  logic [MAX_SLOTS-1:0] bitmap_next;
  logic [CNT_W-1:0]     counter_next;
  logic                 s1_adv;
  logic                 req_fire;

  // Handshake
  assign s1_adv      = s1_valid && (!out_valid || rsp.ready);
  assign req.ready   = !s1_valid || s1_adv;
  assign req_fire    = req.valid && req.ready;
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_item;

  sba_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .req_item     (s1_item),
    .cfg          (cfg),
    .bitmap       (bitmap),
    .counter      (counter),
    .rsp_item     (dp_rsp),
    .bitmap_next  (bitmap_next),
    .counter_next (counter_next)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_address     <= '0;
      cfg.object_size_log2 <= LOG2_RESET;
      cfg.slot_capacity    <= CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_ADDRESS: cfg.base_address     <= cfg_data;
        CFG_OBJ_LOG2:     cfg.object_size_log2 <= cfg_data[LOG2_W-1:0];
        CFG_CAPACITY:     cfg.slot_capacity    <= cfg_data[CNT_W-1:0];
        default:          ;
      endcase
    end
  end

  // Stage control and slab state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      bitmap    <= '1;
      counter   <= CNT_W'(MAX_SLOTS);
    end else begin
      if (req_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
        bitmap    <= bitmap_next;
        counter   <= counter_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item payload registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_item <= req.payload;
    end
    if (s1_adv) begin
      out_item <= dp_rsp;
    end
  end

`ifndef NO_ASSERTIONS
  // Free count always matches the number of free bits
  assert property (@(posedge clk) disable iff (rst)
    int'(counter) == $countones(bitmap))
    else $error("free count out of step with bitmap");

  // A successful allocate clears exactly one bit
  assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_item.action == ACT_ALLOC && dp_rsp.status == ST_OK)
      |-> $countones(bitmap ^ bitmap_next) == 1)
    else $error("allocate changed other than one slot");

  // Only a successful allocate yields a nonzero address
  assert property (@(posedge clk) disable iff (rst)
    (s1_adv && dp_rsp.object_address != '0)
      |-> (s1_item.action == ACT_ALLOC && dp_rsp.status == ST_OK))
    else $error("address returned for non-allocate item");

  // A held input-stage item is never dropped
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_item)))
    else $error("input stage item lost while stalled");
`endif

endmodule

>>> bench/tb.sv
// Self-checking testbench for the slab bitmap allocator: directed and random items.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sba_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RAND_PHASES = 14;
  localparam int PHASE_ITEMS = 107;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] TOP_PAGE = 39'h7F_FFFF_F000;

  // Idle patterns for either side of the block
  localparam int IDLE_NONE = 0;
  localparam int IDLE_FULL = 1;
  localparam int IDLE_RARE = 2;

  // Predicts every result from a copy of the slab state and registers,
  // and holds the results still owed by the block.
  class slab_scoreboard;
    logic [ADDR_W-1:0] base;
    logic [LOG2_W-1:0] size_log2;
    logic [CNT_W-1:0]  capacity;
    logic [63:0]       free_map;
    logic [CNT_W-1:0]  free_cnt;
    rsp_t              owed[$];
    int                errors;

    function new();
      base      = '0;
      size_log2 = LOG2_RESET;
      capacity  = CAP_RESET;
      free_map  = '1;
      free_cnt  = 7'd64;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
      case (idx)
        CFG_BASE_ADDRESS: base = data;
        CFG_OBJ_LOG2:     size_log2 = data[LOG2_W-1:0];
        CFG_CAPACITY:     capacity = data[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] ones_below(int n);
      if (n >= 64) return '1;
      return (64'd1 << n) - 64'd1;
    endfunction

    // Apply one item to the slab and return what the block should answer
    function rsp_t slab_step(req_t it);
      rsp_t              r;
      int                cap;
      int                lg;
      int                slot;
      logic [63:0]       avail;
      logic [ADDR_W-1:0] idx;
      cap = (capacity > 64) ? 64 : int'(capacity);
      if (size_log2 < LOG2_MIN) lg = int'(LOG2_MIN);
      else if (size_log2 > LOG2_MAX) lg = int'(LOG2_MAX);
      else lg = int'(size_log2);
      r.status = ST_OK;
      r.object_address = '0;
      case (it.action)
        ACT_ALLOC: begin
          avail = free_map & ones_below(cap);
          if (free_cnt == 0 || avail == 0) begin
            r.status = ST_NO_FREE;
          end else begin
            slot = 0;
            while (!avail[slot]) slot++;
            free_map[slot] = 1'b0;
            free_cnt = free_cnt - 7'd1;
            r.object_address = base + (ADDR_W'(slot) << lg);
          end
        end
        ACT_FREE: begin
          if (it.free_address < base) begin
            r.status = ST_BAD_ADDR;
          end else begin
            idx = (it.free_address - base) >> lg;
            if (idx >= ADDR_W'(cap)) begin
              r.status = ST_BAD_ADDR;
            end else if (free_map[idx[5:0]]) begin
              r.status = ST_DOUBLE_FREE;
            end else begin
              free_map[idx[5:0]] = 1'b1;
              if (free_cnt != CNT_MAX) free_cnt = free_cnt + 7'd1;
            end
          end
        end
        ACT_INIT: begin
          free_map = ones_below(cap);
          free_cnt = CNT_W'(cap);
        end
        default: ;
      endcase
      r.free_count = free_cnt;
      return r;
    endfunction

    function void note_item(req_t it);
      owed.push_back(slab_step(it));
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got 0x%0h, want 0x%0h", what, got, want);
      errors++;
    endtask

    task check_result(rsp_t got);
      rsp_t want;
      if (owed.size() == 0) begin
        report_mismatch("result with nothing owed", 64'(got), 64'd0);
        return;
      end
      want = owed.pop_front();
      if (got.status != want.status)
        report_mismatch("status", 64'(got.status), 64'(want.status));
      if (got.object_address != want.object_address)
        report_mismatch("object_address", 64'(got.object_address), 64'(want.object_address));
      if (got.free_count != want.free_count)
        report_mismatch("free_count", 64'(got.free_count), 64'(want.free_count));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;
  int                   cycle_count = 0;
  int                   req_mode = IDLE_NONE;
  int                   rsp_mode = IDLE_NONE;
  slab_scoreboard       sb = new();

  sba_if #(.payload_t(req_t)) req_ch ();
  sba_if #(.payload_t(rsp_t)) rsp_ch ();

  slab_bitmap_allocator DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Observe both channels at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) sb.note_item(req_ch.payload);
      if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.payload);
    end
  end

  function automatic int draw_gap(int mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 16);
      default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  function automatic req_t make_item(logic [ACT_W-1:0] act, logic [ADDR_W-1:0] addr);
    req_t it;
    it.action = act;
    it.free_address = addr;
    return it;
  endfunction

  // Result side: random stalls between items
  initial begin
    int gap;
    rsp_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      gap = draw_gap(rsp_mode);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  task automatic send_item(req_t it);
    int gap;
    gap = draw_gap(req_mode);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= it;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Wait until every owed result has come back and the block is quiet
  task automatic drain();
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Write all three registers; upper bits of narrow registers carry noise
  task automatic configure(logic [ADDR_W-1:0] b, logic [LOG2_W-1:0] lg, logic [CNT_W-1:0] cap);
    put_reg(CFG_BASE_ADDRESS, b);
    put_reg(CFG_OBJ_LOG2, (rand_addr() << LOG2_W) | ADDR_W'(lg));
    put_reg(CFG_CAPACITY, (rand_addr() << CNT_W) | ADDR_W'(cap));
    if ($urandom_range(0, 3) == 0) put_reg(CFG_UNUSED, rand_addr());
    cfg_we <= 1'b0;
  endtask

  // One random item, aimed at the current slab layout
  function automatic req_t pick_item(logic [ADDR_W-1:0] b, int lg, int cap, int alloc_pct);
    int                roll;
    int                slot;
    logic [ADDR_W-1:0] addr;
    roll = $urandom_range(0, 99);
    addr = rand_addr();
    if (roll < alloc_pct) return make_item(ACT_ALLOC, addr);
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      // well-formed free of a slot inside the slab, sometimes unaligned
      slot = $urandom_range(0, (cap > 0) ? cap - 1 : 0);
      addr = b + (ADDR_W'(slot) << lg);
      if ($urandom_range(0, 3) == 0)
        addr = addr + (ADDR_W'($urandom) & ((ADDR_W'(1) << lg) - ADDR_W'(1)));
      return make_item(ACT_FREE, addr);
    end
    if (roll < 80) begin
      slot = $urandom_range(cap, cap + 8);
      return make_item(ACT_FREE, b + (ADDR_W'(slot) << lg));
    end
    if (roll < 85) return make_item(ACT_FREE, b - ADDR_W'($urandom_range(1, 4096)));
    if (roll < 90) return make_item(ACT_FREE, addr);
    if (roll < 95) return make_item(ACT_INIT, addr);
    return make_item(($urandom_range(0, 1) == 0) ? ACT_NONE : ACT_ALLOC, addr);
  endfunction

  initial begin
    logic [ADDR_W-1:0] b;
    logic [LOG2_W-1:0] lg;
    logic [CNT_W-1:0]  cap;
    int                lg_eff;
    int                cap_eff;
    int                alloc_pct;
    rst            = 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset layout, basic alloc/free, double free, out of range
    req_mode = IDLE_RARE;
    rsp_mode = IDLE_RARE;
    send_item(make_item(ACT_ALLOC, '0));
    send_item(make_item(ACT_ALLOC, '1));
    send_item(make_item(ACT_FREE, 39'h40));
    send_item(make_item(ACT_FREE, 39'h40));
    send_item(make_item(ACT_FREE, 39'h1000));
    send_item(make_item(ACT_NONE, '1));
    send_item(make_item(ACT_INIT, '0));
    req_ch.valid <= 1'b0;
    drain();

    // Directed: top page base, largest objects, address wrap, unaligned free
    configure(TOP_PAGE, LOG2_MAX, 7'd64);
    send_item(make_item(ACT_ALLOC, '0));
    send_item(make_item(ACT_ALLOC, '0));
    send_item(make_item(ACT_ALLOC, '0));
    send_item(make_item(ACT_FREE, '0));
    send_item(make_item(ACT_FREE, '1));
    req_ch.valid <= 1'b0;
    drain();

    // Directed: empty slab, size below range
    configure('0, 4'd0, 7'd0);
    send_item(make_item(ACT_INIT, '0));
    send_item(make_item(ACT_ALLOC, '0));
    send_item(make_item(ACT_FREE, '0));
    req_ch.valid <= 1'b0;
    drain();

    // Directed: capacity above limit, size above range
    configure(39'h1000, 4'd15, 7'd127);
    send_item(make_item(ACT_ALLOC, '0));
    send_item(make_item(ACT_INIT, '0));
    send_item(make_item(ACT_ALLOC, '0));
    req_ch.valid <= 1'b0;
    drain();

    // Directed: capacity shrunk without init, free slots only above it
    configure(39'h1000, LOG2_MIN, 7'd1);
    send_item(make_item(ACT_ALLOC, '0));
    send_item(make_item(ACT_FREE, 39'h1000));
    send_item(make_item(ACT_ALLOC, '0));
    req_ch.valid <= 1'b0;
    drain();

    // Random phases, each with its own layout and idle pattern
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin b = '0;       lg = LOG2_MIN; cap = 7'd64; end
        1: begin b = TOP_PAGE; lg = LOG2_MAX; cap = 7'd1;  end
        2: begin b = rand_addr() & TOP_PAGE; lg = 4'($urandom_range(0, 15)); cap = 7'd0; end
        3: begin b = rand_addr(); lg = 4'($urandom_range(0, 15)); cap = 7'($urandom_range(65, 127)); end
        default: begin
          b   = ($urandom_range(0, 3) == 0) ? rand_addr() : (rand_addr() & TOP_PAGE);
          lg  = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(LOG2_MIN, LOG2_MAX));
          cap = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
                                            : 7'($urandom_range(1, 64));
        end
      endcase
      req_mode = (ph < 2) ? IDLE_NONE : $urandom_range(IDLE_NONE, IDLE_RARE);
      rsp_mode = (ph < 2) ? IDLE_NONE : $urandom_range(IDLE_NONE, IDLE_RARE);
      configure(b, lg, cap);
      if (lg < LOG2_MIN) lg_eff = int'(LOG2_MIN);
      else if (lg > LOG2_MAX) lg_eff = int'(LOG2_MAX);
      else lg_eff = int'(lg);
      cap_eff = (cap > 64) ? 64 : int'(cap);
      alloc_pct = $urandom_range(25, 70);
      if ($urandom_range(0, 4) != 0) send_item(make_item(ACT_INIT, rand_addr()));
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_item(pick_item(b, lg_eff, cap_eff, alloc_pct));
      req_ch.valid <= 1'b0;
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.owed.size() != 0)
      sb.report_mismatch("results never returned", 64'(sb.owed.size()), 64'd0);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
